// ----- rtl/tsm_pkg.sv -----
// Shared types and constants for the two-way sorted merge block.
package tsm_pkg;

  localparam int unsigned KEY_W           = 64;
  localparam int unsigned DEF_QUEUE_DEPTH = 32;

  typedef enum logic {
    OP_LEFT  = 1'b0,
    OP_RIGHT = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic [KEY_W-1:0]   key;
    logic               stream_end;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   merged_key;
    logic               final_key;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;    // exactly one key held
  } queue_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_OVF
  } state_e;

endpackage

// ----- rtl/tsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tsm_queue.sv -----
// Circular key queue: RAM storage plus head/tail pointers and fill count.
module tsm_queue import tsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  queue_ctrl_t      ctrl_i,
  input  logic [KEY_W-1:0] key_i,
  output logic [KEY_W-1:0] head_o,
  output queue_stat_t      stat_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d  = ctrl_i.pop  ? ptr_inc(head_q) : head_q;
    tail_d  = ctrl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    unique case ({ctrl_i.push, ctrl_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Read port follows the head pointer; the read data is registered, so it lags the pointer.
  tsm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (tail_q),
    .wdata_i (key_i),
    .raddr_i (head_q),
    .rdata_o (head_o)
  );

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.one   = (count_q == CW'(1));

endmodule

// ----- rtl/two_way_sorted_merge.sv -----
// Top level of the stable two-way merge of ascending 64-bit key streams.
// Each request pushes one key into the left or right queue (QUEUE_DEPTH keys
// each, held in RAM); the block then emits merged keys while a decision can be
// made, ties going to the left, and flags the last key of the merge. After a
// request is accepted, each merged key takes a queue RAM read of the new heads
// and then a compare and pop. A request whose last released key ends the merge
// returns to idle after that key; any other push ends with one more read and
// compare that finds no decision. A push after the end of its stream is
// ignored, and a push to a full queue is dropped and reported as an overflow
// item. A result waiting in the output register does not block the next
// request; the block only stalls when it needs that slot.
module two_way_sorted_merge import tsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e      state_q, state_d;
  logic        left_ended_q, left_ended_d;
  logic        right_ended_q, right_ended_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  queue_ctrl_t lq_ctrl, rq_ctrl;
  queue_stat_t lq_stat, rq_stat;
  logic [KEY_W-1:0] l_head, r_head;

  logic accept, slot_free, sel_right, sel_ended, sel_full;
  logic l_ne, r_ne, emit, take_r, fin, load_out;

  tsm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lq_ctrl),
    .key_i  (in_item_i.key),
    .head_o (l_head),
    .stat_o (lq_stat)
  );

  tsm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rq_ctrl),
    .key_i  (in_item_i.key),
    .head_o (r_head),
    .stat_o (rq_stat)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign sel_right  = (op_e'(in_item_i.operation) == OP_RIGHT);
  assign sel_ended  = sel_right ? right_ended_q : left_ended_q;
  assign sel_full   = sel_right ? rq_stat.full : lq_stat.full;

  // Merge decision on the current heads.
  assign l_ne = !lq_stat.empty;
  assign r_ne = !rq_stat.empty;

  always_comb begin
    emit   = 1'b0;
    take_r = 1'b0;
    priority if (l_ne && r_ne) begin
      emit   = 1'b1;
      take_r = (r_head < l_head);
    end else if (l_ne && right_ended_q) begin
      emit   = 1'b1;
    end else if (r_ne && left_ended_q) begin
      emit   = 1'b1;
      take_r = 1'b1;
    end else begin
      emit   = 1'b0;
    end
  end

  assign fin = left_ended_q && right_ended_q &&
               (take_r ? (rq_stat.one && !l_ne) : (lq_stat.one && !r_ne));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !sel_ended) begin
          state_d = sel_full ? ST_OVF : ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (!emit) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          state_d = fin ? ST_IDLE : ST_READ;
        end
      end
      ST_OVF: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    lq_ctrl       = '0;
    rq_ctrl       = '0;
    left_ended_d  = left_ended_q;
    right_ended_d = right_ended_q;
    load_out      = 1'b0;
    out_item_d    = out_item_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !sel_ended && !sel_full) begin
          if (sel_right) begin
            rq_ctrl.push  = 1'b1;
            right_ended_d = right_ended_q || in_item_i.stream_end;
          end else begin
            lq_ctrl.push  = 1'b1;
            left_ended_d  = left_ended_q || in_item_i.stream_end;
          end
        end
      end
      ST_CMP: begin
        if (emit && slot_free) begin
          load_out              = 1'b1;
          out_item_d.merged_key = take_r ? r_head : l_head;
          out_item_d.final_key  = fin;
          out_item_d.overflow   = 1'b0;
          rq_ctrl.pop           = take_r;
          lq_ctrl.pop           = !take_r;
          if (fin) begin
            left_ended_d  = 1'b0;
            right_ended_d = 1'b0;
          end
        end
      end
      ST_OVF: begin
        if (slot_free) begin
          load_out              = 1'b1;
          out_item_d.merged_key = '0;
          out_item_d.final_key  = 1'b0;
          out_item_d.overflow   = 1'b1;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      left_ended_q  <= 1'b0;
      right_ended_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      left_ended_q  <= left_ended_d;
      right_ended_q <= right_ended_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // Writes and head reads never overlap, so the RAM needs no forwarding.
  a_push_pop_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lq_ctrl.push || rq_ctrl.push) |-> !(lq_ctrl.pop || rq_ctrl.pop))
    else $error("push and pop in the same cycle");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lq_ctrl.pop && lq_stat.empty) && !(rq_ctrl.pop && rq_stat.empty))
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lq_ctrl.push && lq_stat.full) && !(rq_ctrl.push && rq_stat.full))
    else $error("push into full queue");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_item_d.final_key) |=>
      (!left_ended_q && !right_ended_q && lq_stat.empty && rq_stat.empty))
    else $error("merge state not cleared after final key");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && $past(state_q) != ST_CMP) |-> $past(state_q) == ST_READ)
    else $error("compare without a head read");
`endif

endmodule
